### rtl/core/bounded_queue_task_dispatcher_unit_macros.svh
// assertion macros for the task dispatcher
`ifndef BOUNDED_QUEUE_TASK_DISPATCHER_UNIT_MACROS_SVH
`define BOUNDED_QUEUE_TASK_DISPATCHER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BQTD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BQTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/bqtd_pkg.sv
// shared constants, types and codes of the task dispatcher
`default_nettype none
package bqtd_pkg;

    localparam int QUEUE_DEPTH    = 8;
    localparam int NUM_PROCESSORS = 4;

    localparam int QA_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int PA_W   = (NUM_PROCESSORS > 1) ? $clog2(NUM_PROCESSORS) : 1;
    localparam int PC_W   = $clog2(NUM_PROCESSORS + 1);

    localparam int CAP_W  = 4;
    localparam int NPROC_W = 3;
    localparam int CFG_DATA_W = 4;
    localparam int TIME_W = 4;
    localparam int IDX_W  = 16;
    localparam int MASK_W = 4;
    localparam int FILL_W = 4;
    localparam int CNT_W  = 32;
    localparam int OUT_DATA_W = 192;
    localparam int IN_DATA_W  = 8;

    localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(3);
    localparam logic [NPROC_W-1:0] NPROC_RESET = NPROC_W'(1);

    // register indexes of the configuration port
    localparam logic CFG_QUEUE_CAPACITY    = 1'b0;
    localparam logic CFG_PROCESSORS_IN_USE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_PROC,
        ST_SCAN,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load_in;
        logic arrive;
        logic proc_next;
        logic idle_hit;
        logic scan_start;
        logic scan_step;
        logic pop_done;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic proc_done;
        logic proc_busy;
        logic queue_empty;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

### rtl/core/bqtd_ctrl.sv
// sequencer for one tick: arrival, processor scan, queue search, result
`default_nettype none
module bqtd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bqtd_pkg::dp_status_t st,
    output bqtd_pkg::dp_cmd_t        cmd
);

    bqtd_pkg::ctrl_state_t state_reg;
    bqtd_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bqtd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bqtd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = bqtd_pkg::ST_ARRIVE;
                end
            end
            bqtd_pkg::ST_ARRIVE: begin
                cmd.arrive = 1'b1;
                state_next = bqtd_pkg::ST_PROC;
            end
            bqtd_pkg::ST_PROC: begin
                priority if (st.proc_done) begin
                    state_next = bqtd_pkg::ST_FINISH;
                end else if (st.proc_busy) begin
                    cmd.proc_next = 1'b1;
                end else if (st.queue_empty) begin
                    // idle processor with nothing queued ends the scan
                    cmd.idle_hit = 1'b1;
                    state_next   = bqtd_pkg::ST_FINISH;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = bqtd_pkg::ST_SCAN;
                end
            end
            bqtd_pkg::ST_SCAN: begin
                if (st.scan_last) begin
                    cmd.pop_done = 1'b1;
                    state_next   = bqtd_pkg::ST_PROC;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            bqtd_pkg::ST_FINISH: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = bqtd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bqtd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/bqtd_datapath.sv
// queue store, processor countdowns, totals and the result register
`default_nettype none
module bqtd_datapath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic                                   cfg_wr_index,
    input  wire logic [bqtd_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
    input  wire logic                                   in_arrival,
    input  wire logic [bqtd_pkg::TIME_W-1:0]            in_time,
    input  wire bqtd_pkg::dp_cmd_t                      cmd,
    output bqtd_pkg::dp_status_t                        st,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [bqtd_pkg::OUT_DATA_W-1:0]             out_data
);

    localparam int ENT_W = bqtd_pkg::IDX_W + bqtd_pkg::TIME_W;

    function automatic logic [bqtd_pkg::CNT_W-1:0] sat_add(
        input logic [bqtd_pkg::CNT_W-1:0] a,
        input logic [bqtd_pkg::CNT_W-1:0] b
    );
        logic [bqtd_pkg::CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[bqtd_pkg::CNT_W] ? '1 : sum[bqtd_pkg::CNT_W-1:0];
    endfunction

    // configuration
    logic [bqtd_pkg::CAP_W-1:0]   cap_reg;
    logic [bqtd_pkg::NPROC_W-1:0] nproc_reg;
    logic [bqtd_pkg::QC_W-1:0]    cap_eff;
    logic [bqtd_pkg::PC_W-1:0]    nproc_eff;

    // captured input word
    logic                         arr_reg;
    logic [bqtd_pkg::TIME_W-1:0]  time_reg;

    // queue store
    logic [ENT_W-1:0]             mem [bqtd_pkg::QUEUE_DEPTH];
    logic [ENT_W-1:0]             rd_data_reg;
    logic [bqtd_pkg::QA_W-1:0]    rd_addr;
    logic                         rd_en;
    logic                         wr_en;
    logic [bqtd_pkg::QA_W-1:0]    wr_addr;
    logic [ENT_W-1:0]             wr_data;
    logic [bqtd_pkg::QC_W-1:0]    count_reg;

    // search over the queue
    logic [bqtd_pkg::QA_W-1:0]    scan_k_reg;
    logic [bqtd_pkg::QA_W-1:0]    best_slot_reg;
    logic [bqtd_pkg::IDX_W-1:0]   best_idx_reg;
    logic [bqtd_pkg::TIME_W-1:0]  best_time_reg;
    logic [bqtd_pkg::QA_W-1:0]    sel_slot;
    logic [bqtd_pkg::IDX_W-1:0]   sel_idx;
    logic [bqtd_pkg::TIME_W-1:0]  sel_time;
    logic [bqtd_pkg::IDX_W-1:0]   rd_idx;
    logic [bqtd_pkg::TIME_W-1:0]  rd_time;
    logic                         take;

    // processors
    logic [bqtd_pkg::TIME_W-1:0]  rem_reg [bqtd_pkg::NUM_PROCESSORS];
    logic [bqtd_pkg::PC_W-1:0]    proc_i_reg;
    logic [bqtd_pkg::PA_W-1:0]    proc_sel;

    // tick results and totals
    logic [bqtd_pkg::IDX_W-1:0]   next_index_reg;
    logic                         acc_reg;
    logic                         den_reg;
    logic [bqtd_pkg::IDX_W-1:0]   idx_reg;
    logic [bqtd_pkg::MASK_W-1:0]  mask_reg;
    logic [bqtd_pkg::CNT_W-1:0]   arrivals_reg;
    logic [bqtd_pkg::CNT_W-1:0]   denials_reg;
    logic [bqtd_pkg::CNT_W-1:0]   waiting_reg;
    logic [bqtd_pkg::CNT_W-1:0]   idle_reg;
    logic [bqtd_pkg::CNT_W-1:0]   work_reg;
    logic                         out_valid_reg;
    logic [bqtd_pkg::OUT_DATA_W-1:0] out_data_reg;

    assign cap_eff = ({1'b0, cap_reg} > (bqtd_pkg::CAP_W+1)'(bqtd_pkg::QUEUE_DEPTH))
                   ? bqtd_pkg::QC_W'(bqtd_pkg::QUEUE_DEPTH)
                   : bqtd_pkg::QC_W'(cap_reg);
    assign nproc_eff = ({1'b0, nproc_reg} > (bqtd_pkg::NPROC_W+1)'(bqtd_pkg::NUM_PROCESSORS))
                     ? bqtd_pkg::PC_W'(bqtd_pkg::NUM_PROCESSORS)
                     : bqtd_pkg::PC_W'(nproc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= bqtd_pkg::CAP_RESET;
            nproc_reg <= bqtd_pkg::NPROC_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                bqtd_pkg::CFG_QUEUE_CAPACITY:
                    cap_reg <= cfg_wr_data[bqtd_pkg::CAP_W-1:0];
                bqtd_pkg::CFG_PROCESSORS_IN_USE:
                    nproc_reg <= cfg_wr_data[bqtd_pkg::NPROC_W-1:0];
                default: ;
            endcase
        end
    end

    // queue store ports
    assign proc_sel = proc_i_reg[bqtd_pkg::PA_W-1:0];
    assign rd_en    = cmd.scan_start | cmd.scan_step;
    assign rd_addr  = cmd.scan_start ? '0 : scan_k_reg + 1'b1;
    assign rd_idx   = rd_data_reg[ENT_W-1:bqtd_pkg::TIME_W];
    assign rd_time  = rd_data_reg[bqtd_pkg::TIME_W-1:0];

    // strict compare keeps the lowest slot on a full tie
    assign take = (scan_k_reg == '0) || (rd_idx > best_idx_reg) ||
                  ((rd_idx == best_idx_reg) && (rd_time > best_time_reg));
    assign sel_slot = take ? scan_k_reg : best_slot_reg;
    assign sel_idx  = take ? rd_idx     : best_idx_reg;
    assign sel_time = take ? rd_time    : best_time_reg;

    // pop moves the last entry, which the final search read returned, into the hole
    assign wr_en   = (cmd.arrive && arr_reg && (count_reg < cap_eff)) || cmd.pop_done;
    assign wr_addr = cmd.pop_done ? sel_slot : count_reg[bqtd_pkg::QA_W-1:0];
    assign wr_data = cmd.pop_done ? rd_data_reg : {next_index_reg, time_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            arr_reg  <= in_arrival;
            time_reg <= in_time;
        end
        if (cmd.scan_start) begin
            scan_k_reg <= '0;
        end else if (cmd.scan_step) begin
            scan_k_reg <= scan_k_reg + 1'b1;
        end
        if (cmd.scan_step) begin
            best_slot_reg <= sel_slot;
            best_idx_reg  <= sel_idx;
            best_time_reg <= sel_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            proc_i_reg     <= '0;
            next_index_reg <= '0;
            acc_reg        <= 1'b0;
            den_reg        <= 1'b0;
            idx_reg        <= '0;
            mask_reg       <= '0;
            arrivals_reg   <= '0;
            denials_reg    <= '0;
            waiting_reg    <= '0;
            idle_reg       <= '0;
            work_reg       <= '0;
            out_valid_reg  <= 1'b0;
            for (int p = 0; p < bqtd_pkg::NUM_PROCESSORS; p++) begin
                rem_reg[p] <= '0;
            end
        end else begin
            if (cmd.load_in) begin
                acc_reg    <= 1'b0;
                den_reg    <= 1'b0;
                idx_reg    <= '0;
                mask_reg   <= '0;
                proc_i_reg <= '0;
            end
            if (cmd.arrive && arr_reg) begin
                idx_reg        <= next_index_reg;
                next_index_reg <= next_index_reg + 1'b1;
                arrivals_reg   <= sat_add(arrivals_reg, bqtd_pkg::CNT_W'(1));
                work_reg       <= sat_add(work_reg, bqtd_pkg::CNT_W'(time_reg));
                if (count_reg < cap_eff) begin
                    count_reg <= count_reg + 1'b1;
                    acc_reg   <= 1'b1;
                end else begin
                    denials_reg <= sat_add(denials_reg, bqtd_pkg::CNT_W'(1));
                    den_reg     <= 1'b1;
                end
            end
            if (cmd.proc_next) begin
                proc_i_reg <= proc_i_reg + 1'b1;
            end
            if (cmd.idle_hit) begin
                idle_reg <= sat_add(idle_reg, bqtd_pkg::CNT_W'(1));
            end
            if (cmd.pop_done) begin
                rem_reg[proc_sel]  <= sel_time;
                count_reg          <= count_reg - 1'b1;
                mask_reg[proc_sel] <= 1'b1;
                proc_i_reg         <= proc_i_reg + 1'b1;
            end
            if (cmd.finish) begin
                if (count_reg != '0) begin
                    waiting_reg <= sat_add(waiting_reg, bqtd_pkg::CNT_W'(1));
                end
                for (int p = 0; p < bqtd_pkg::NUM_PROCESSORS; p++) begin
                    if (rem_reg[p] != '0) begin
                        rem_reg[p] <= rem_reg[p] - 1'b1;
                    end
                end
            end
            if (cmd.finish) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word, highest field first; waiting total is this tick's final value
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {
                6'd0,
                work_reg,
                idle_reg,
                (count_reg != '0) ? sat_add(waiting_reg, bqtd_pkg::CNT_W'(1)) : waiting_reg,
                denials_reg,
                arrivals_reg,
                bqtd_pkg::FILL_W'(count_reg),
                mask_reg,
                idx_reg,
                den_reg,
                acc_reg
            };
        end
    end

    assign st.proc_done   = (proc_i_reg >= nproc_eff);
    assign st.proc_busy   = (rem_reg[proc_sel] != '0);
    assign st.queue_empty = (count_reg == '0);
    assign st.scan_last   = ({1'b0, scan_k_reg} == (bqtd_pkg::QC_W'(count_reg) - 1'b1));
    assign st.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

### rtl/core/bounded_queue_task_dispatcher_unit.sv
// Bounded queue task dispatcher, one tick per input word.
//
// Input stream: each word is one time tick; s_axis_tuser says a task arrives
// and s_axis_tdata carries its service time. Output stream: one result word
// per tick with the arrival verdict, its index, the dispatch mask, the queue
// fill after dispatch and five saturating totals.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_wr_index
// (0 queue capacity, 1 processors in use); write only while the block idles.
// Throughput: one tick at a time. A tick records the arrival, visits the
// processors in use and registers the result; each dispatch finds the newest
// task by reading the queue store one entry per cycle through its single read
// port. The next word is taken the cycle after the result is registered.
// Reset (aresetn low, synchronous): queue empty, all processors idle, index
// and totals zero, capacity 3, one processor.
// A stalled output holds its word; the block finishes the next tick and then
// waits for the output register to drain before loading it.
`default_nettype none
module bounded_queue_task_dispatcher_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic                                cfg_wr_index,
    input  wire logic [bqtd_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [3:0] task_time, [7:4] zero
    input  wire logic [bqtd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] arrival
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [0] accepted, [1] denied, [17:2] task_index, [21:18] dispatch_mask,
    // [25:22] queue_fill, [57:26] received_count, [89:58] denied_count,
    // [121:90] wait_ticks, [153:122] idle_ticks, [185:154] total_work, [191:186] zero
    output logic [bqtd_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

    bqtd_pkg::dp_cmd_t    cmd;
    bqtd_pkg::dp_status_t st;

    bqtd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .st       (st),
        .cmd      (cmd)
    );

    bqtd_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_arrival   (s_axis_tuser),
        .in_time      (s_axis_tdata[bqtd_pkg::TIME_W-1:0]),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (m_axis_tdata)
    );

`include "bounded_queue_task_dispatcher_unit_macros.svh"

    `BQTD_ASSERT_NEXT(a_one_tick_at_a_time,
        s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "word accepted while a tick is in progress")
    `BQTD_ASSERT_NOW(a_verdict_exclusive,
        m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[1]),
        "arrival both accepted and denied")
    `BQTD_ASSERT_NOW(a_fill_bounded,
        m_axis_tvalid, m_axis_tdata[25:22] <= 4'(bqtd_pkg::QUEUE_DEPTH),
        "queue fill beyond depth")

endmodule
`default_nettype wire
